// ===== hw/rtl/date_add_signed_days_macros.svh =====
// Assertion macros used by the checker file of the date adder.
`ifndef DATE_ADD_SIGNED_DAYS_MACROS_SVH
`define DATE_ADD_SIGNED_DAYS_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define DASD_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define DASD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DASD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/dasd_pkg.sv =====
// Package with the widths, codes, types and month table of the date adder.
`default_nettype none

package dasd_pkg;

  localparam int OFFSET_WIDTH = 17;

  localparam int YEAR_W  = 14;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
  localparam logic [YEAR_W-1:0]  ERA_YEARS = 14'd400;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_DATE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    reduce;
    logic    step;
    logic    finish;
    status_t status;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic reduced;
    logic date_ok;
    logic step_last;
    logic step_ovf;
  } dp_sts_t;

  // Month length; February gets its extra day in leap years.
  // Codes that name no month give zero, which no valid day fits.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dasd_datapath.sv =====
// Datapath of the date adder: date registers, remaining day count and month walk.
`default_nettype none

module dasd_datapath (
  input  wire logic                                      clk,
  input  wire logic [dasd_pkg::YEAR_W-1:0]               start_year,
  input  wire logic [dasd_pkg::MONTH_W-1:0]              start_month,
  input  wire logic [dasd_pkg::DAY_W-1:0]                start_day,
  input  wire logic signed [dasd_pkg::OFFSET_WIDTH-1:0]  offset_days,
  input  wire dasd_pkg::dp_cmd_t                         cmd,
  output dasd_pkg::dp_sts_t                              sts,
  output logic [dasd_pkg::YEAR_W-1:0]                    result_year,
  output logic [dasd_pkg::MONTH_W-1:0]                   result_month,
  output logic [dasd_pkg::DAY_W-1:0]                     result_day,
  output logic [1:0]                                     status
);
  import dasd_pkg::*;

  logic [YEAR_W-1:0]       y;
  logic [MONTH_W-1:0]      m;
  logic [DAY_W-1:0]        d;
  logic [YEAR_W-1:0]       yrem;
  logic                    back;
  logic [OFFSET_WIDTH-1:0] mag;
  status_t                 status_q;

  logic [OFFSET_WIDTH-1:0] offset_u;
  logic [8:0]              mod400;
  logic [6:0]              mod100;
  logic                    leap;
  logic [DAY_W-1:0]        dim;
  logic [DAY_W-1:0]        prev_dim;
  logic [DAY_W-1:0]        left;
  logic                    fwd_last;
  logic                    back_last;

  assign offset_u = OFFSET_WIDTH'(unsigned'(offset_days));

  // After the reduction yrem holds the year modulo 400.
  always_comb begin
    mod400 = yrem[8:0];
    priority if (mod400 >= 9'd300) begin
      mod100 = 7'(mod400 - 9'd300);
    end else if (mod400 >= 9'd200) begin
      mod100 = 7'(mod400 - 9'd200);
    end else if (mod400 >= 9'd100) begin
      mod100 = 7'(mod400 - 9'd100);
    end else begin
      mod100 = 7'(mod400);
    end
    leap      = (mod400 == 9'd0) || ((y[1:0] == 2'b00) && (mod100 != 7'd0));
    dim       = month_len(m, leap);
    // Stepping back from March lands in February of the same year.
    prev_dim  = (m == MONTH_JAN) ? month_len(MONTH_DEC, 1'b0) : month_len(m - 4'd1, leap);
    left      = dim - d;
    fwd_last  = mag <= OFFSET_WIDTH'(left);
    back_last = mag < OFFSET_WIDTH'(d);

    sts.reduced   = yrem < ERA_YEARS;
    sts.date_ok   = (y >= YEAR_MIN) && (y <= YEAR_MAX) && (m >= MONTH_JAN) &&
                    (m <= MONTH_DEC) && (d != 5'd0) && (d <= dim);
    sts.step_last = back ? back_last : fwd_last;
    sts.step_ovf  = back ? (!back_last && (m == MONTH_JAN) && (y == YEAR_MIN))
                         : (!fwd_last && (m == MONTH_DEC) && (y == YEAR_MAX));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      y    <= start_year;
      m    <= start_month;
      d    <= start_day;
      yrem <= start_year;
      back <= offset_days[OFFSET_WIDTH-1];
      mag  <= offset_days[OFFSET_WIDTH-1] ? (~offset_u + OFFSET_WIDTH'(1)) : offset_u;
    end
    if (cmd.reduce) begin
      yrem <= yrem - ERA_YEARS;
    end
    if (cmd.step) begin
      if (!back) begin
        if (fwd_last) begin
          d <= d + mag[DAY_W-1:0];
        end else begin
          mag <= mag - OFFSET_WIDTH'(left) - OFFSET_WIDTH'(1);
          d   <= 5'd1;
          if (m == MONTH_DEC) begin
            m    <= MONTH_JAN;
            y    <= y + 14'd1;
            yrem <= (yrem == ERA_YEARS - 14'd1) ? 14'd0 : yrem + 14'd1;
          end else begin
            m <= m + 4'd1;
          end
        end
      end else begin
        if (back_last) begin
          d <= d - mag[DAY_W-1:0];
        end else begin
          mag <= mag - OFFSET_WIDTH'(d);
          d   <= prev_dim;
          if (m == MONTH_JAN) begin
            m    <= MONTH_DEC;
            y    <= y - 14'd1;
            yrem <= (yrem == 14'd0) ? ERA_YEARS - 14'd1 : yrem - 14'd1;
          end else begin
            m <= m - 4'd1;
          end
        end
      end
    end
    if (cmd.finish) begin
      status_q <= cmd.status;
      if (cmd.status == STATUS_OK) begin
        result_year  <= y;
        result_month <= m;
        result_day   <= d;
      end else begin
        result_year  <= '0;
        result_month <= '0;
        result_day   <= '0;
      end
    end
  end

  assign status = status_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dasd_controller.sv =====
// Controller state machine of the date adder.
`default_nettype none

module dasd_controller (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire dasd_pkg::dp_sts_t sts,
  output dasd_pkg::dp_cmd_t      cmd,
  output logic                   busy,
  output logic                   done
);
  import dasd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.status = STATUS_OK;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (sts.reduced) begin
          state_next = ST_CHECK;
        end else begin
          cmd.reduce = 1'b1;
        end
      end
      ST_CHECK: begin
        if (sts.date_ok) begin
          state_next = ST_WALK;
        end else begin
          cmd.finish = 1'b1;
          cmd.status = STATUS_BAD_DATE;
          state_next = ST_IDLE;
        end
      end
      ST_WALK: begin
        if (sts.step_ovf) begin
          cmd.finish = 1'b1;
          cmd.status = STATUS_RANGE;
          state_next = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
          if (sts.step_last) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/date_add_signed_days.sv =====
// Top level of the date adder: adds a signed day count to a Gregorian date.
//
//   Channel   Beat marked by        Fields
//   -------   -------------------   -------------------------------------------------
//   input     start high, busy low  start_year, start_month, start_day, offset_days
//   result    done high (1 cycle)   result_year, result_month, result_day, status
//
// After acceptance an item passes the year reduction, the date check, the month walk and
// the finish state, and then shows the done beat. The walk crosses M month boundaries
// (about 2160 at most for a 17-bit offset), one month per cycle, and stops early when the
// year would leave the range. The year reduction subtracts 400 until the year code lies
// below 400, for the leap test; a bad start date ends right after the check.
// busy is high from the cycle after acceptance until the done beat; start is
// ignored meanwhile. A new item may be accepted in the cycle that shows done.
// The receiver cannot stall, so the result is shown exactly once, in one cycle.
// Reset (rst, synchronous) returns the controller to idle and clears done.
`default_nettype none

module date_add_signed_days (
  input  wire logic                                      clk,
  input  wire logic                                      rst,
  input  wire logic                                      start,
  output logic                                           busy,
  input  wire logic [dasd_pkg::YEAR_W-1:0]               start_year,
  input  wire logic [dasd_pkg::MONTH_W-1:0]              start_month,
  input  wire logic [dasd_pkg::DAY_W-1:0]                start_day,
  input  wire logic signed [dasd_pkg::OFFSET_WIDTH-1:0]  offset_days,
  output logic                                           done,
  output logic [dasd_pkg::YEAR_W-1:0]                    result_year,
  output logic [dasd_pkg::MONTH_W-1:0]                   result_month,
  output logic [dasd_pkg::DAY_W-1:0]                     result_day,
  output logic [1:0]                                     status
);
  import dasd_pkg::*;

  // Commands and status between the two halves. The controller loads the
  // date on acceptance, reduces the year modulo 400 for the leap test,
  // validates the date, then walks a month per cycle while watching the
  // year range, and finally has the datapath latch the result fields.
  dp_cmd_t cmd;
  dp_sts_t sts;

  dasd_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // The datapath holds the date, the remaining magnitude and the direction.
  // Result fields are zero whenever the status is not ok.
  dasd_datapath u_dp (
    .clk          (clk),
    .start_year   (start_year),
    .start_month  (start_month),
    .start_day    (start_day),
    .offset_days  (offset_days),
    .cmd          (cmd),
    .sts          (sts),
    .result_year  (result_year),
    .result_month (result_month),
    .result_day   (result_day),
    .status       (status)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/dasd_checker.sv =====
// Port-level checker of the date adder and its bind to the top level.
`default_nettype none
`include "date_add_signed_days_macros.svh"

module dasd_checker (
  input wire logic                                      clk,
  input wire logic                                      rst,
  input wire logic                                      start,
  input wire logic                                      busy,
  input wire logic [dasd_pkg::YEAR_W-1:0]               start_year,
  input wire logic [dasd_pkg::MONTH_W-1:0]              start_month,
  input wire logic [dasd_pkg::DAY_W-1:0]                start_day,
  input wire logic signed [dasd_pkg::OFFSET_WIDTH-1:0]  offset_days,
  input wire logic                                      done,
  input wire logic [dasd_pkg::YEAR_W-1:0]               result_year,
  input wire logic [dasd_pkg::MONTH_W-1:0]              result_month,
  input wire logic [dasd_pkg::DAY_W-1:0]                result_day,
  input wire logic [1:0]                                status
);
  import dasd_pkg::*;

  logic err_zero;
  logic ok_range;

  assign err_zero = (result_year == '0) && (result_month == '0) && (result_day == '0);
  assign ok_range = (result_year >= YEAR_MIN) && (result_year <= YEAR_MAX) &&
                    (result_month >= MONTH_JAN) && (result_month <= MONTH_DEC) &&
                    (result_day != '0);

  // A result beat always ends the item, so the block is free again.
  `DASD_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "done while busy")
  // An accepted item keeps the block busy in the following cycle.
  `DASD_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "not busy after accept")
  // No result beat follows directly on acceptance.
  `DASD_ASSERT_NEXT(a_accept_nodone, clk, rst, start && !busy, !done, "done right after accept")
  // Error results carry zero date fields.
  `DASD_ASSERT_IMP(a_err_zero, clk, rst, done && (status != STATUS_OK), err_zero,
    "error result with nonzero date")
  // Good results lie within the calendar range.
  `DASD_ASSERT_IMP(a_ok_range, clk, rst, done && (status == STATUS_OK), ok_range,
    "ok result outside calendar range")

endmodule

bind date_add_signed_days dasd_checker u_dasd_checker (.*);

`default_nettype wire
